// File: sv/tsm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tsm_pkg: shared types and codes for the task state manager
// Request codes, status codes, entry states and the modulo stamp compare.
// ----------------------------------------------------------------------------
package tsm_pkg;

	typedef enum logic [2:0] {
		REQ_SWITCH = 3'd0,
		REQ_FORK   = 3'd1,
		REQ_EXIT   = 3'd2,
		REQ_SLEEP  = 3'd3,
		REQ_WAKEUP = 3'd4,
		REQ_WAIT   = 3'd5
	} req_t;

	typedef enum logic [2:0] {
		RS_OK       = 3'd0,
		RS_NO_FREE  = 3'd1,
		RS_REFUSED  = 3'd2,
		RS_BAD_EVT  = 3'd3,
		RS_NO_CHILD = 3'd4,
		RS_SLEPT    = 3'd5,
		RS_EMPTY    = 3'd6
	} rstat_t;

	typedef enum logic [2:0] {
		ES_FREE   = 3'd0,
		ES_READY  = 3'd1,
		ES_SLEEP  = 3'd2,
		ES_ZOMBIE = 3'd3,
		ES_RUN    = 3'd4
	} estat_t;

	localparam int STAMP_W = 16;

	// a comes before b when (a - b) mod 2^16 has its top bit set
	function automatic logic earlier(input logic [STAMP_W-1:0] a,
		input logic [STAMP_W-1:0] b);
		logic [STAMP_W-1:0] d;
		d = a - b;
		return d[STAMP_W-1];
	endfunction

endpackage
`default_nettype wire

// File: sv/task_state_manager_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// task_state_manager_top: hardware task table and scheduler
// Running task, priority ready queue, sleep list, free list and child lists.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with req_type/req_value while busy is low; that beat is taken
//   and busy rises. The block walks the task table one entry per cycle with a
//   single scan/compare unit under a small sequencer. When done it pulses
//   done for one cycle with result_status, result_id, result_exit_code,
//   woken_count and running_id; the receiver cannot stall, so the result is
//   simply presented for that cycle.
// Walks: a walk scans every table entry, then a step acts on the winner;
//   exit adds a parent check step. Refused requests, sleeps with a bad
//   event and unknown requests take no walk. Switch, fork and sleep take
//   one walk, wait two (one with no child, three if the caller sleeps),
//   wakeup one per woken sleeper plus one, exit one per child plus one, one
//   per woken sleeper plus one when the parent sleeps, then one for the
//   switch. busy drops as done rises, so the next request can be taken at
//   the edge that ends the done cycle.
// Reset: entry 0 runs, all others free; queue stamps 0..N-1, stamp counter N.
//   Every table register is set at reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module task_state_manager_top #(
	parameter int ENTRY_COUNT = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	output logic                      busy,
	input  wire logic [2:0]           req_type,
	input  wire logic signed [31:0]   req_value,
	output logic                      done,
	output logic [2:0]                result_status,
	output logic [3:0]                result_id,
	output logic signed [31:0]        result_exit_code,
	output logic [4:0]                woken_count,
	output logic [3:0]                running_id
);
	import tsm_pkg::*;

	localparam int IW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;
	localparam logic [IW-1:0] LAST = IW'(ENTRY_COUNT - 1);
	localparam logic [IW-1:0] ONE  = IW'(1);
	localparam logic [IW-1:0] ZERO = '0;

	// scan purposes
	typedef enum logic [2:0] {
		SC_READY, SC_SLEEP, SC_FREE, SC_CHILD, SC_ZCHILD
	} scan_t;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SW_PICK, S_FORK, S_EXIT_CH, S_EXIT_PAR,
		S_WAKE, S_WAIT_ANY, S_WAIT_Z, S_DONE
	} state_t;

	estat_t             st_q   [ENTRY_COUNT];
	logic               pri_q  [ENTRY_COUNT];
	logic [31:0]        evt_q  [ENTRY_COUNT];
	logic [31:0]        code_q [ENTRY_COUNT];
	logic [IW-1:0]      par_q  [ENTRY_COUNT];
	logic [STAMP_W-1:0] qst_q  [ENTRY_COUNT];
	logic [STAMP_W-1:0] cst_q  [ENTRY_COUNT];
	logic [IW-1:0]      cur_q;
	logic [STAMP_W-1:0] cnt_q;

	state_t        state_q, ret_q;
	req_t          req_q;
	logic [31:0]   mev_q;     // event to match in sleep scans
	scan_t         scan_q;
	logic [IW-1:0] idx_q, best_q;
	logic          found_q;
	logic          pend_sw_q; // switch still to be done after this phase
	logic          slept_q;   // wait put caller to sleep
	logic [4:0]    woken_q;

	// one candidate test and compare per cycle
	logic cand, better;
	always_comb begin
		cand = 1'b0;
		case (scan_q)
			SC_READY:  cand = (st_q[idx_q] == ES_READY);
			SC_SLEEP:  cand = (st_q[idx_q] == ES_SLEEP) && (evt_q[idx_q] == mev_q);
			SC_FREE:   cand = (st_q[idx_q] == ES_FREE);
			SC_CHILD:  cand = (st_q[idx_q] != ES_FREE) && (idx_q != cur_q)
				&& (par_q[idx_q] == cur_q);
			SC_ZCHILD: cand = (st_q[idx_q] == ES_ZOMBIE) && (idx_q != cur_q)
				&& (par_q[idx_q] == cur_q);
			default:   cand = 1'b0;
		endcase
		better = 1'b0;
		if (cand) begin
			if (!found_q) begin
				better = 1'b1;
			end else begin
				case (scan_q)
					SC_READY, SC_SLEEP:
						better = (pri_q[idx_q] && !pri_q[best_q]) ||
							((pri_q[idx_q] == pri_q[best_q]) &&
							 earlier(qst_q[idx_q], qst_q[best_q]));
					SC_FREE:
						better = earlier(qst_q[idx_q], qst_q[best_q]);
					default:
						better = earlier(cst_q[idx_q], cst_q[best_q]);
				endcase
			end
		end
	end

	assign busy = (state_q != S_IDLE);
	assign running_id = 4'(cur_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ENTRY_COUNT; i++) begin
				st_q[i]   <= ES_FREE;
				pri_q[i]  <= 1'b0;
				evt_q[i]  <= '0;
				code_q[i] <= '0;
				par_q[i]  <= '0;
				qst_q[i]  <= STAMP_W'(i);
				cst_q[i]  <= '0;
			end
			st_q[0]   <= ES_RUN;
			cur_q     <= '0;
			cnt_q     <= STAMP_W'(ENTRY_COUNT);
			state_q   <= S_IDLE;
			ret_q     <= S_IDLE;
			req_q     <= REQ_SWITCH;
			mev_q     <= '0;
			scan_q    <= SC_READY;
			idx_q     <= '0;
			best_q    <= '0;
			found_q   <= 1'b0;
			pend_sw_q <= 1'b0;
			slept_q   <= 1'b0;
			woken_q   <= '0;
			done      <= 1'b0;
			result_status    <= '0;
			result_id        <= '0;
			result_exit_code <= '0;
			woken_count      <= '0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						req_q     <= req_t'(req_type);
						woken_q   <= '0;
						slept_q   <= 1'b0;
						pend_sw_q <= 1'b0;
						result_status    <= RS_OK;
						result_id        <= '0;
						result_exit_code <= '0;
						idx_q   <= ZERO;
						found_q <= 1'b0;
						state_q <= S_SCAN;
						case (req_t'(req_type))
							REQ_SWITCH: begin
								if (st_q[cur_q] == ES_RUN) begin
									st_q[cur_q]  <= ES_READY;
									qst_q[cur_q] <= cnt_q;
									cnt_q        <= cnt_q + 1'b1;
								end
								scan_q <= SC_READY;
								ret_q  <= S_SW_PICK;
							end
							REQ_FORK: begin
								scan_q <= SC_FREE;
								ret_q  <= S_FORK;
							end
							REQ_EXIT: begin
								if (cur_q == ONE) begin
									result_status <= RS_REFUSED;
									state_q <= S_DONE;
								end else begin
									code_q[cur_q] <= req_value;
									st_q[cur_q]   <= ES_ZOMBIE;
									pri_q[cur_q]  <= 1'b0;
									scan_q <= SC_CHILD;
									ret_q  <= S_EXIT_CH;
								end
							end
							REQ_SLEEP: begin
								if (cur_q == ONE) begin
									result_status <= RS_REFUSED;
									state_q <= S_DONE;
								end else if (req_value <= 0) begin
									result_status <= RS_BAD_EVT;
									state_q <= S_DONE;
								end else begin
									evt_q[cur_q] <= req_value;
									st_q[cur_q]  <= ES_SLEEP;
									qst_q[cur_q] <= cnt_q;
									cnt_q        <= cnt_q + 1'b1;
									scan_q <= SC_READY;
									ret_q  <= S_SW_PICK;
								end
							end
							REQ_WAKEUP: begin
								mev_q  <= req_value;
								scan_q <= SC_SLEEP;
								ret_q  <= S_WAKE;
							end
							REQ_WAIT: begin
								scan_q <= SC_CHILD;
								ret_q  <= S_WAIT_ANY;
							end
							default: begin
								result_status <= RS_REFUSED;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (better) begin
						best_q  <= idx_q;
						found_q <= 1'b1;
					end
					if (idx_q == LAST) begin
						state_q <= ret_q;
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				S_SW_PICK: begin
					if (found_q) begin
						st_q[best_q] <= ES_RUN;
						cur_q <= best_q;
						if (slept_q) result_status <= RS_SLEPT;
					end else begin
						result_status <= RS_EMPTY;
					end
					state_q <= S_DONE;
				end
				S_FORK: begin
					if (!found_q) begin
						result_status <= RS_NO_FREE;
					end else begin
						par_q[best_q] <= cur_q;
						cst_q[best_q] <= cnt_q;
						qst_q[best_q] <= cnt_q + 1'b1;
						cnt_q         <= cnt_q + 2'd2;
						st_q[best_q]  <= ES_READY;
						pri_q[best_q] <= 1'b1;
						result_id     <= 4'(best_q);
					end
					state_q <= S_DONE;
				end
				S_EXIT_CH: begin
					idx_q   <= ZERO;
					found_q <= 1'b0;
					if (found_q) begin
						// next child moves behind task 1's children
						par_q[best_q] <= ONE;
						cst_q[best_q] <= cnt_q;
						cnt_q         <= cnt_q + 1'b1;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_EXIT_PAR;
					end
				end
				S_EXIT_PAR: begin
					pend_sw_q <= 1'b1;
					if (st_q[par_q[cur_q]] == ES_SLEEP) begin
						mev_q  <= 32'(par_q[cur_q]);
						scan_q <= SC_SLEEP;
						ret_q  <= S_WAKE;
						state_q <= S_SCAN;
					end else begin
						woken_count <= '0;
						scan_q <= SC_READY;
						ret_q  <= S_SW_PICK;
						state_q <= S_SCAN;
					end
				end
				S_WAKE: begin
					idx_q   <= ZERO;
					found_q <= 1'b0;
					if (found_q) begin
						evt_q[best_q] <= '0;
						st_q[best_q]  <= ES_READY;
						qst_q[best_q] <= cnt_q;
						cnt_q         <= cnt_q + 1'b1;
						if (woken_q != 5'd31) woken_q <= woken_q + 1'b1;
						state_q <= S_SCAN;
					end else if (pend_sw_q) begin
						// exit: switch after waking (zombie is not requeued)
						woken_count <= woken_q;
						scan_q  <= SC_READY;
						ret_q   <= S_SW_PICK;
						state_q <= S_SCAN;
					end else begin
						woken_count <= woken_q;
						state_q <= S_DONE;
					end
				end
				S_WAIT_ANY: begin
					if (!found_q) begin
						result_status <= RS_NO_CHILD;
						state_q <= S_DONE;
					end else begin
						idx_q   <= ZERO;
						found_q <= 1'b0;
						scan_q  <= SC_ZCHILD;
						ret_q   <= S_WAIT_Z;
						state_q <= S_SCAN;
					end
				end
				S_WAIT_Z: begin
					if (found_q) begin
						result_id        <= 4'(best_q);
						result_exit_code <= code_q[best_q];
						st_q[best_q]  <= ES_FREE;
						par_q[best_q] <= ZERO;
						qst_q[best_q] <= cnt_q;
						cnt_q         <= cnt_q + 1'b1;
						state_q <= S_DONE;
					end else if (cur_q == ZERO) begin
						result_status <= RS_BAD_EVT;
						state_q <= S_DONE;
					end else begin
						evt_q[cur_q] <= 32'(cur_q);
						st_q[cur_q]  <= ES_SLEEP;
						qst_q[cur_q] <= cnt_q;
						cnt_q        <= cnt_q + 1'b1;
						slept_q <= 1'b1;
						idx_q   <= ZERO;
						found_q <= 1'b0;
						scan_q  <= SC_READY;
						ret_q   <= S_SW_PICK;
						state_q <= S_SCAN;
					end
				end
				S_DONE: begin
					if (req_q != REQ_WAKEUP && req_q != REQ_EXIT) woken_count <= '0;
					if (req_q == REQ_EXIT && !pend_sw_q) woken_count <= '0;
					done    <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
